// ===== sv/ume_pkg.sv =====
// Shared types and constants for the unique mesh edge collector.
// No dependencies; every other file of the block imports this package.
package ume_pkg;

  // Table depth and vertex index width.
  localparam int MAX_EDGES   = 256;
  localparam int VERTEX_BITS = 20;

  // An edge key is (low << VERTEX_BITS) | high.
  localparam int KEY_W = 2 * VERTEX_BITS;

  // Counter width that can hold 0 .. MAX_EDGES.
  localparam int CNT_W = $clog2(MAX_EDGES + 1);

  // Edges per triangle and the index of the last one.
  localparam int EDGES_PER_TRI = 3;
  localparam logic [1:0] LAST_EDGE_IDX = 2'(EDGES_PER_TRI - 1);

  // One stored table entry of a cell.
  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } entry_t;

  // An edge traveling down the insertion chain. A dead item keeps moving so
  // that every item walks the whole chain and leaves it at the far end.
  typedef struct packed {
    logic             valid;
    logic             alive;
    logic             probe;
    logic             inserted;
    logic [KEY_W-1:0] key;
  } token_t;

  // Table-wide commands broadcast to every cell.
  typedef struct packed {
    logic rotate;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== sv/ume_in_if.sv =====
// Input channel of the edge collector: valid, ready and one triangle or drain item.
// Depends on ume_pkg for the vertex width.
interface ume_in_if;
  import ume_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [VERTEX_BITS-1:0] vertex_a;
  logic [VERTEX_BITS-1:0] vertex_b;
  logic [VERTEX_BITS-1:0] vertex_c;
  logic                   triangle_shown;
  logic [2:0]             edge_select;

  modport source (
    output valid, mode, vertex_a, vertex_b, vertex_c, triangle_shown, edge_select,
    input  ready
  );

  modport sink (
    input  valid, mode, vertex_a, vertex_b, vertex_c, triangle_shown, edge_select,
    output ready
  );
endinterface

// ===== sv/ume_out_if.sv =====
// Output channel of the edge collector: valid, ready and one drained edge item.
// Depends on ume_pkg for the vertex width.
interface ume_out_if;
  import ume_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VERTEX_BITS-1:0] low_vertex;
  logic [VERTEX_BITS-1:0] high_vertex;
  logic                   edge_valid;
  logic                   last_edge;
  logic                   overflow;

  modport source (
    output valid, low_vertex, high_vertex, edge_valid, last_edge, overflow,
    input  ready
  );

  modport sink (
    input  valid, low_vertex, high_vertex, edge_valid, last_edge, overflow,
    output ready
  );
endinterface

// ===== sv/ume_cell.sv =====
// One cell of the sorted edge chain: holds one table entry and passes a traveling
// edge to its right neighbor each cycle. Depends on ume_pkg.
module ume_cell (
  input  logic               clk,
  input  logic               rst,
  input  ume_pkg::cell_ctl_t ctl,
  input  ume_pkg::token_t    tok_in,
  input  ume_pkg::entry_t    rot_in,
  output ume_pkg::token_t    tok_out,
  output ume_pkg::entry_t    entry
);
  import ume_pkg::*;

  token_t tok_next;
  entry_t entry_next;
  logic   key_eq;
  logic   key_lt;

  assign key_eq = (tok_in.key == entry.key);
  assign key_lt = (tok_in.key <  entry.key);

  // Insertion step: fill an empty cell, drop a duplicate, or keep the smaller
  // key here and push the larger one onward. A probe only looks for a match.
  always_comb begin
    tok_next   = tok_in;
    entry_next = entry;
    if (tok_in.valid && tok_in.alive) begin
      if (tok_in.probe) begin
        if (entry.used && key_eq) begin
          tok_next.alive = 1'b0;
        end
      end else if (!entry.used) begin
        entry_next.used    = 1'b1;
        entry_next.key     = tok_in.key;
        tok_next.alive     = 1'b0;
        tok_next.inserted  = 1'b1;
      end else if (key_eq) begin
        tok_next.alive = 1'b0;
      end else if (key_lt) begin
        entry_next.key = tok_in.key;
        tok_next.key   = entry.key;
      end
    end
  end

  // Clear and rotate only happen while no edge is in the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.used    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      priority if (ctl.clear) begin
        entry.used    <= 1'b0;
        tok_out.valid <= 1'b0;
      end else if (ctl.rotate) begin
        entry         <= rot_in;
        tok_out.valid <= 1'b0;
      end else begin
        entry   <= entry_next;
        tok_out <= tok_next;
      end
    end
  end

endmodule

// ===== sv/ume_chain.sv =====
// Row of MAX_EDGES cells forming the sorted unique edge table.
// Depends on ume_pkg and ume_cell.
module ume_chain (
  input  logic               clk,
  input  logic               rst,
  input  ume_pkg::cell_ctl_t ctl,
  input  ume_pkg::token_t    launch,
  output ume_pkg::token_t    exit_tok,
  output ume_pkg::entry_t    head
);
  import ume_pkg::*;

  token_t tok [MAX_EDGES];
  entry_t ent [MAX_EDGES];

  // Edges enter at cell 0; rotation moves every entry one cell toward the head.
  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
    if (i == 0) begin : g_first
      ume_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .tok_in  (launch),
        .rot_in  (ent[(i + 1) % MAX_EDGES]),
        .tok_out (tok[i]),
        .entry   (ent[i])
      );
    end else begin : g_rest
      ume_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .tok_in  (tok[i - 1]),
        .rot_in  (ent[(i + 1) % MAX_EDGES]),
        .tok_out (tok[i]),
        .entry   (ent[i])
      );
    end
  end

  assign exit_tok = tok[MAX_EDGES - 1];
  assign head     = ent[0];

endmodule

// ===== sv/unique_mesh_edge_collector_top.sv =====
// Top level of the unique mesh edge collector: item sequencer, counters and result register.
// Depends on ume_pkg, ume_in_if, ume_out_if and ume_chain.
//
//   channel | dir | contents
//   req     | in  | mode, vertex_a/b/c, triangle_shown, edge_select
//   rsp     | out | low_vertex, high_vertex, edge_valid, last_edge, overflow
//
// A triangle sends one edge a cycle into the cell chain unless an edge waits
// for room, and each edge walks the whole chain while later edges follow it.
// A drain waits until the chain holds no edge and the result register is
// free. A triangle after a partial drain first rotates the table back into order.
// When the table is nearly full, edges wait until the chain is empty.
// Reset is synchronous; a result waits in its register until rsp takes it.
module unique_mesh_edge_collector_top (
  input logic      clk,
  input logic      rst,
  ume_in_if.sink   req,
  ume_out_if.source rsp
);
  import ume_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESTORE,
    S_INSERT,
    S_DRAIN
  } state_t;

  localparam logic [CNT_W:0]   MAX_SUM = (CNT_W + 1)'(MAX_EDGES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_EDGES);

  state_t                 state;
  state_t                 acc_state;
  logic [VERTEX_BITS-1:0] va;
  logic [VERTEX_BITS-1:0] vb;
  logic [VERTEX_BITS-1:0] vc;
  logic                   shown;
  logic [2:0]             sel;
  logic [1:0]             eidx;
  logic [CNT_W-1:0]       rot_left;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       pos;
  logic [CNT_W-1:0]       inflight;
  logic                   ovf;

  logic                   out_valid;
  logic [VERTEX_BITS-1:0] out_low;
  logic [VERTEX_BITS-1:0] out_high;
  logic                   out_edge;
  logic                   out_last;
  logic                   out_ovf;

  logic [VERTEX_BITS-1:0] ep;
  logic [VERTEX_BITS-1:0] eq;
  logic [VERTEX_BITS-1:0] lo;
  logic [VERTEX_BITS-1:0] hi;
  logic                   need;
  logic                   room;
  logic                   full_idle;
  logic                   go;
  logic                   finishing;
  logic                   req_acc;
  logic                   drain_go;
  logic                   last_hit;
  token_t                 launch;
  token_t                 exit_tok;
  entry_t                 head;
  cell_ctl_t              ctl;

  // Endpoints of the current edge, ordered low before high.
  always_comb begin
    unique case (eidx)
      2'd0:    begin ep = va; eq = vb; end
      2'd1:    begin ep = vb; eq = vc; end
      2'd2:    begin ep = vc; eq = va; end
      default: begin ep = va; eq = vb; end
    endcase
    lo = (ep < eq) ? ep : eq;
    hi = (ep < eq) ? eq : ep;
  end

  // An edge may insert while a free cell is certain; on a full table it
  // probes for a duplicate once every earlier edge has left the chain.
  assign need      = shown && sel[eidx];
  assign room      = ({1'b0, count} + {1'b0, inflight}) < MAX_SUM;
  assign full_idle = (inflight == '0) && (count == MAX_CNT);
  assign go        = !need || room || full_idle;
  assign finishing = (state == S_INSERT) && (eidx == LAST_EDGE_IDX) && go;

  always_comb begin
    launch.valid    = (state == S_INSERT) && need && go;
    launch.alive    = 1'b1;
    launch.probe    = !room;
    launch.inserted = 1'b0;
    launch.key      = {lo, hi};
  end

  assign req.ready = (state == S_IDLE) || finishing;
  assign req_acc   = req.valid && req.ready;

  // Where a newly accepted item goes.
  always_comb begin
    if (req.mode) begin
      acc_state = S_DRAIN;
    end else if (pos != '0) begin
      acc_state = S_RESTORE;
    end else if (req.triangle_shown) begin
      acc_state = S_INSERT;
    end else begin
      acc_state = S_IDLE;
    end
  end

  // Drain step: needs an empty chain and a free result register.
  assign drain_go = (state == S_DRAIN) && (inflight == '0) && (!out_valid || rsp.ready);
  assign last_hit = ({1'b0, pos} + 1'b1) >= {1'b0, count};

  always_comb begin
    ctl.rotate = (state == S_RESTORE) || (drain_go && (count != '0) && !last_hit);
    ctl.clear  = drain_go && ((count == '0) || last_hit);
  end

  ume_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .launch   (launch),
    .exit_tok (exit_tok),
    .head     (head)
  );

  // Sequencer, table counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pos       <= '0;
      inflight  <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      eidx      <= '0;
    end else begin
      inflight <= inflight + CNT_W'(launch.valid) - CNT_W'(exit_tok.valid);
      if (exit_tok.valid && exit_tok.inserted) begin
        count <= count + 1'b1;
      end
      if (exit_tok.valid && exit_tok.alive) begin
        ovf <= 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      // A new item is taken in idle or on the last edge of a triangle.
      if (req_acc) begin
        state    <= acc_state;
        va       <= req.vertex_a;
        vb       <= req.vertex_b;
        vc       <= req.vertex_c;
        shown    <= req.triangle_shown;
        sel      <= req.edge_select;
        eidx     <= '0;
        rot_left <= MAX_CNT - pos;
        if (!req.mode) begin
          pos <= '0;
        end
      end else begin
        unique case (state)
          S_IDLE: begin
          end
          S_RESTORE: begin
            rot_left <= rot_left - 1'b1;
            if (rot_left == CNT_W'(1)) begin
              state <= shown ? S_INSERT : S_IDLE;
            end
          end
          S_INSERT: begin
            if (go) begin
              if (eidx == LAST_EDGE_IDX) begin
                state <= S_IDLE;
              end else begin
                eidx <= eidx + 1'b1;
              end
            end
          end
          S_DRAIN: begin
            if (drain_go) begin
              state     <= S_IDLE;
              out_valid <= 1'b1;
              out_ovf   <= ovf;
              if (count == '0) begin
                out_low  <= '0;
                out_high <= '0;
                out_edge <= 1'b0;
                out_last <= 1'b0;
                count    <= '0;
                pos      <= '0;
                ovf      <= 1'b0;
              end else begin
                out_low  <= head.key[KEY_W-1:VERTEX_BITS];
                out_high <= head.key[VERTEX_BITS-1:0];
                out_edge <= 1'b1;
                out_last <= last_hit;
                if (last_hit) begin
                  count <= '0;
                  pos   <= '0;
                  ovf   <= 1'b0;
                end else begin
                  pos <= pos + 1'b1;
                end
              end
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.low_vertex  = out_low;
  assign rsp.high_vertex = out_high;
  assign rsp.edge_valid  = out_edge;
  assign rsp.last_edge   = out_last;
  assign rsp.overflow    = out_ovf;

  // Committed and traveling edges never exceed the table depth; the only extra
  // edge is a single duplicate probe walking a full table.
  a_no_oversubscribe: assert property (@(posedge clk) disable iff (rst)
    (({1'b0, count} + {1'b0, inflight}) <= MAX_SUM) ||
    ((count == MAX_CNT) && (inflight == CNT_W'(1))))
    else $error("edge count plus traveling edges exceeds table depth");

  // A probe is launched only on a full table with an empty chain.
  a_probe_when_full: assert property (@(posedge clk) disable iff (rst)
    (launch.valid && launch.probe) |-> (count == MAX_CNT) && (inflight == '0))
    else $error("probe launched while table not full or chain busy");

  // The overflow flag rises only when a probe left the chain unmatched.
  a_ovf_source: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> $past(exit_tok.valid && exit_tok.alive))
    else $error("overflow set without an unmatched probe");

  // After the last edge is drained the table is empty.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (drain_go && (count != '0) && last_hit) |=> (count == '0) && (pos == '0))
    else $error("table not cleared after last edge");

endmodule
